@@ rtl/rgsa_pkg.sv @@
// ----------------------------------------------------------------------------
// rgsa_pkg
// Shared constants, item types and controller/datapath interface structs for
// the row gather / scatter-add core.
// ----------------------------------------------------------------------------
package rgsa_pkg;

    localparam int CLASS_DEPTH    = 256;
    localparam int POSITION_DEPTH = 64;
    localparam int ROW_MAX        = 16;
    localparam int ELEM_WIDTH     = 32;

    localparam int CLS_AW  = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
    localparam int POS_AW  = (POSITION_DEPTH > 1) ? $clog2(POSITION_DEPTH) : 1;
    localparam int COL_AW  = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
    localparam int LEN_W   = $clog2(ROW_MAX + 1) > COL_AW ? $clog2(ROW_MAX + 1) : COL_AW;

    localparam int CT_DEPTH = CLASS_DEPTH * ROW_MAX;
    localparam int PB_DEPTH = POSITION_DEPTH * ROW_MAX;
    localparam int CT_AW    = (CT_DEPTH > 1) ? $clog2(CT_DEPTH) : 1;
    localparam int PB_AW    = (PB_DEPTH > 1) ? $clog2(PB_DEPTH) : 1;

    // item modes
    localparam logic [2:0] MODE_WR_TABLE = 3'd0;
    localparam logic [2:0] MODE_WR_BUF   = 3'd1;
    localparam logic [2:0] MODE_EXEC     = 3'd2;
    localparam logic [2:0] MODE_RD_TABLE = 3'd3;
    localparam logic [2:0] MODE_RD_BUF   = 3'd4;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCUMULATE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT = 2'd3;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [15:0] class_index;
        logic [5:0]         position;
        logic [3:0]         column;
        logic signed [31:0] word_value;
        logic               batch_start;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] read_word;
        logic               index_out_of_range;
        logic               error_seen;
    } t_out_item;

    typedef struct packed {
        logic              capture;
        logic              word_wr;
        logic              word_rd;
        logic              walk_rd;
        logic              walk_wr;
        logic [COL_AW-1:0] rd_col;
        logic [COL_AW-1:0] wr_col;
        logic              load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic             walk_go;
        logic [LEN_W-1:0] row_len;
    } t_dp_stat;

endpackage

@@ rtl/rgsa_ram.sv @@
// ----------------------------------------------------------------------------
// rgsa_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rgsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                     i_clk,
    input  logic                                     i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                         i_wr_data,
    input  logic                                     i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/rgsa_ctrl.sv @@
// ----------------------------------------------------------------------------
// rgsa_ctrl
// Item sequencer: accepts a word, steps the row walk one element per cycle
// with the write in the cycle after the read, and hands off the result word.
// ----------------------------------------------------------------------------
module rgsa_ctrl
    import rgsa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_WALK,
        S_FINISH
    } t_state;

    t_state            r_state, n_state;
    logic [LEN_W-1:0]  r_rd_cnt, n_rd_cnt;
    logic              r_wr_pend, n_wr_pend;
    logic [COL_AW-1:0] r_wr_col, n_wr_col;
    logic              r_out_valid, n_out_valid;
    logic              rd_more;

    assign rd_more = r_rd_cnt < i_stat.row_len;

    always_comb begin
        n_state     = r_state;
        n_rd_cnt    = r_rd_cnt;
        n_wr_pend   = r_wr_pend;
        n_wr_col    = r_wr_col;
        n_out_valid = r_out_valid && i_out_stall;

        o_cmd          = '0;
        o_cmd.rd_col   = r_rd_cnt[COL_AW-1:0];
        o_cmd.wr_col   = r_wr_col;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_START;
                end
            end
            S_START: begin
                o_cmd.word_wr = 1'b1;
                o_cmd.word_rd = 1'b1;
                n_rd_cnt      = '0;
                n_wr_pend     = 1'b0;
                n_state       = i_stat.walk_go ? S_WALK : S_FINISH;
            end
            S_WALK: begin
                o_cmd.walk_rd = rd_more;
                o_cmd.walk_wr = r_wr_pend;
                if (rd_more) begin
                    n_rd_cnt  = r_rd_cnt + LEN_W'(1);
                    n_wr_pend = 1'b1;
                    n_wr_col  = r_rd_cnt[COL_AW-1:0];
                end else begin
                    // last write goes out this cycle
                    n_wr_pend = 1'b0;
                    n_state   = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_cnt    <= '0;
            r_wr_pend   <= 1'b0;
            r_wr_col    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_cnt    <= n_rd_cnt;
            r_wr_pend   <= n_wr_pend;
            r_wr_col    <= n_wr_col;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/rgsa_dp.sv @@
// ----------------------------------------------------------------------------
// rgsa_dp
// Datapath: configuration registers, item register, class table and position
// buffer RAMs, element adder, sticky error flag and result register.
// ----------------------------------------------------------------------------
module rgsa_dp
    import rgsa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_item              i_item,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output t_out_item             o_item
);

    logic       r_reverse;
    logic       r_accumulate;
    logic [4:0] r_row_length;
    logic [8:0] r_class_count;
    logic       r_sticky, n_sticky;

    t_in_item   r_item;
    t_out_item  r_out, n_out;

    logic [31:0] limit;
    logic        cls_ok, exec_idx_ok, pos_ok, col_ok;
    logic        is_wr_table, is_wr_buf, is_rd_table, is_rd_buf, is_exec;
    logic        oor;
    logic [CLS_AW-1:0] cls_row;
    logic [POS_AW-1:0] pos_row;
    logic [CT_AW-1:0]  ct_row_base;
    logic [PB_AW-1:0]  pb_row_base;

    logic                  ct_wr_en, ct_rd_en, pb_wr_en, pb_rd_en;
    logic [CT_AW-1:0]      ct_wr_addr, ct_rd_addr;
    logic [PB_AW-1:0]      pb_wr_addr, pb_rd_addr;
    logic [ELEM_WIDTH-1:0] ct_rd_data, pb_rd_data;
    logic [ELEM_WIDTH-1:0] store_word, src_elem, dst_elem, new_elem;
    logic [31:0]           rd_value;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reverse     <= 1'b0;
            r_accumulate  <= 1'b0;
            r_row_length  <= 5'd1;
            r_class_count <= 9'd256;
        end else if (i_cfg_wr) begin
            case (i_cfg_index)
                CFG_REVERSE:     r_reverse     <= i_cfg_data[0];
                CFG_ACCUMULATE:  r_accumulate  <= i_cfg_data[0];
                CFG_ROW_LENGTH:  r_row_length  <= i_cfg_data[4:0];
                CFG_CLASS_COUNT: r_class_count <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
    end

    // decode of the held item
    assign is_wr_table = (r_item.mode == MODE_WR_TABLE);
    assign is_wr_buf   = (r_item.mode == MODE_WR_BUF);
    assign is_rd_table = (r_item.mode == MODE_RD_TABLE);
    assign is_rd_buf   = (r_item.mode == MODE_RD_BUF);
    assign is_exec     = (r_item.mode == MODE_EXEC);

    assign limit = (32'(r_class_count) > CLASS_DEPTH) ? 32'(CLASS_DEPTH)
                                                      : 32'(r_class_count);
    assign cls_ok      = !r_item.class_index[15] &&
                         (32'(r_item.class_index[14:0]) < 32'(CLASS_DEPTH));
    assign exec_idx_ok = !r_item.class_index[15] &&
                         (32'(r_item.class_index[14:0]) < limit);
    assign pos_ok      = 32'(r_item.position) < 32'(POSITION_DEPTH);
    assign col_ok      = 32'(r_item.column) < 32'(ROW_MAX);
    assign oor         = is_exec && !exec_idx_ok;

    assign o_stat.row_len = (32'(r_row_length) > ROW_MAX) ? LEN_W'(ROW_MAX)
                                                          : LEN_W'(r_row_length);
    assign o_stat.walk_go = is_exec && exec_idx_ok && pos_ok && (o_stat.row_len != '0);

    assign cls_row     = CLS_AW'(r_item.class_index[14:0]);
    assign pos_row     = POS_AW'(r_item.position);
    assign ct_row_base = CT_AW'(cls_row) * CT_AW'(ROW_MAX);
    assign pb_row_base = PB_AW'(pos_row) * PB_AW'(ROW_MAX);

    assign store_word = ELEM_WIDTH'(r_item.word_value);

    // row walk: source and destination come back together in the cycle after issue
    assign src_elem = r_reverse ? pb_rd_data : ct_rd_data;
    assign dst_elem = r_reverse ? ct_rd_data : pb_rd_data;
    assign new_elem = r_accumulate ? (src_elem + dst_elem) : src_elem;

    assign ct_wr_en   = (i_cmd.word_wr && is_wr_table && cls_ok && col_ok) ||
                        (i_cmd.walk_wr && r_reverse);
    assign ct_wr_addr = ct_row_base + CT_AW'(i_cmd.word_wr ? COL_AW'(r_item.column)
                                                           : i_cmd.wr_col);
    assign ct_rd_en   = (i_cmd.word_rd && is_rd_table && cls_ok && col_ok) ||
                        i_cmd.walk_rd;
    assign ct_rd_addr = ct_row_base + CT_AW'(i_cmd.word_rd ? COL_AW'(r_item.column)
                                                           : i_cmd.rd_col);

    assign pb_wr_en   = (i_cmd.word_wr && is_wr_buf && pos_ok && col_ok) ||
                        (i_cmd.walk_wr && !r_reverse);
    assign pb_wr_addr = pb_row_base + PB_AW'(i_cmd.word_wr ? COL_AW'(r_item.column)
                                                           : i_cmd.wr_col);
    assign pb_rd_en   = (i_cmd.word_rd && is_rd_buf && pos_ok && col_ok) ||
                        i_cmd.walk_rd;
    assign pb_rd_addr = pb_row_base + PB_AW'(i_cmd.word_rd ? COL_AW'(r_item.column)
                                                           : i_cmd.rd_col);

    rgsa_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (CT_DEPTH)
    ) u_class_table (
        .i_clk     (i_clk),
        .i_wr_en   (ct_wr_en),
        .i_wr_addr (ct_wr_addr),
        .i_wr_data (i_cmd.word_wr ? store_word : new_elem),
        .i_rd_en   (ct_rd_en),
        .i_rd_addr (ct_rd_addr),
        .o_rd_data (ct_rd_data)
    );

    rgsa_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (PB_DEPTH)
    ) u_position_buf (
        .i_clk     (i_clk),
        .i_wr_en   (pb_wr_en),
        .i_wr_addr (pb_wr_addr),
        .i_wr_data (i_cmd.word_wr ? store_word : new_elem),
        .i_rd_en   (pb_rd_en),
        .i_rd_addr (pb_rd_addr),
        .o_rd_data (pb_rd_data)
    );

    // read data is still held in the RAM output register at finish
    always_comb begin
        rd_value = '0;
        if (is_rd_table && cls_ok && col_ok) begin
            rd_value = 32'(signed'(ct_rd_data));
        end else if (is_rd_buf && pos_ok && col_ok) begin
            rd_value = 32'(signed'(pb_rd_data));
        end
    end

    always_comb begin
        n_sticky = (r_sticky && !r_item.batch_start) || oor;
        n_out.read_word          = rd_value;
        n_out.index_out_of_range = oor;
        n_out.error_seen         = n_sticky;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sticky <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_sticky <= n_sticky;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= n_out;
        end
    end

    assign o_item = r_out;

endmodule

@@ rtl/row_gather_scatter_add_core.sv @@
// ----------------------------------------------------------------------------
// row_gather_scatter_add_core
// Row gather / scatter-add engine over a class table and a position buffer.
// ----------------------------------------------------------------------------
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+------------------------
//  input   | i_in_valid, o_in_stall, i_in_data         | valid && !stall
//  output  | o_out_valid, i_out_stall, o_out_data      | valid && !stall
//  config  | i_cfg_valid, o_cfg_ready, i_cfg_index,    | valid && ready
//          | i_cfg_data                                |
//
// Word reads and writes, unknown modes and executes that move nothing go from
// accept through a start state to a finish state that loads the result
// register. An execute that walks a row steps through row_length elements
// (row_length saturated at ROW_MAX) in a walk state between start and finish:
// the row walk reads one element of each RAM per cycle and writes the
// destination element in the cycle after. The input stalls until a word is done.
// Reset is synchronous, active low; RAM contents are not cleared.
// A result waits in the output register under stall while the next word is
// already taken in; finishing that next word waits for the register to free.
// ----------------------------------------------------------------------------
module row_gather_scatter_add_core
    import rgsa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    rgsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    rgsa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_item      (o_out_data)
    );

endmodule
